// ===== design/bfsm_pkg.sv =====
// Shared constants for the string membership filter.
// No dependencies; imported by the top level.
package bfsm_pkg;

  localparam int MaxCells = 1024;                 // filter bits in the store
  localparam int AddrW    = $clog2(MaxCells);     // store address width
  localparam int CfgW     = 11;                   // cell count register width
  localparam int HashW    = 32;                   // running hash width
  localparam int StepW    = $clog2(HashW);        // remainder step counter width

  localparam logic [HashW-1:0] Djb2Start    = HashW'(5381);
  localparam logic [HashW-1:0] SdbmStart    = '0;
  localparam logic [CfgW-1:0]  CellCountRst = CfgW'(1024);

  localparam int TdataInW  = 8;   // key_byte
  localparam int TuserInW  = 2;   // func, byte_valid
  localparam int TdataOutW = 8;   // is_member, zero fill
  localparam int TuserOutW = 1;   // was_query

  // Operation codes carried in the func field
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncQuery  = 1'b1;

endpackage

// ===== design/bloom_filter_string_membership.sv =====
// Bloom filter for byte strings, djb2 and sdbm hashes, top level.
// Depends on bfsm_pkg and bfsm_ram.
//
// Key strings stream in one byte per transfer; each byte marked byte_valid updates
// both running hashes in the cycle it is accepted, so bytes go at one per cycle
// while tready is high. On the transfer marked tlast the string finishes: both
// hashes are reduced modulo the cell count by a bit-serial remainder unit (one
// hash bit per cycle, both hashes side by side), then the bit store is written
// (insert) or read (query), and one result transfer is produced. The block is
// busy from a string's final transfer until its result is handed to the output
// register; tready is low meanwhile. A finished result sits in an output
// register, so the next string's bytes are taken while it waits.
// After reset the bit store is swept to zero, one entry per cycle, with tready
// low; cell count writes are taken throughout. A cell count of zero acts as
// one, and values above the store size saturate.
module bloom_filter_string_membership
  import bfsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cell count register
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  // key byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataInW-1:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic [TuserInW-1:0]  s_axis_tuser,   // [0] func, [1] byte_valid
  input  logic                 s_axis_tlast,   // last_byte
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata,   // [0] is_member
  output logic [TuserOutW-1:0] m_axis_tuser    // [0] was_query
);

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;  // sweep store to zero
  localparam logic [2:0] StIdle  = 3'd1;  // taking bytes
  localparam logic [2:0] StDiv   = 3'd2;  // remainder steps
  localparam logic [2:0] StAddrA = 3'd3;  // write/read first bit
  localparam logic [2:0] StAddrB = 3'd4;  // write/read second bit
  localparam logic [2:0] StRes   = 3'd5;  // hand result to output register

  logic [2:0]       state_q, state_d;
  logic [CfgW-1:0]  cells_q;
  logic [HashW-1:0] h1_q, h1_d, h2_q, h2_d;
  logic [HashW-1:0] h1_upd, h2_upd, byte_ext;
  logic [HashW-1:0] q1_q, q1_d, q2_q, q2_d;     // dividends, shifted out MSB first
  logic [CfgW-1:0]  r1_q, r1_d, r2_q, r2_d;     // partial remainders
  logic [StepW-1:0] step_q, step_d;
  logic [AddrW:0]   clr_q, clr_d;
  logic             func_q, func_d;
  logic             bit_a_q, bit_a_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_data_q, out_data_d;
  logic [CfgW-1:0]  n_eff;
  logic             in_xfer, out_free;

  // store port
  logic             mem_we, mem_wdata, mem_rdata;
  logic [AddrW-1:0] mem_waddr, mem_raddr, addr_a, addr_b;

  bfsm_ram #(
    .Width (1),
    .Depth (MaxCells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // effective modulus: zero acts as one, saturate at store size
  always_comb begin
    n_eff = cells_q;
    if (cells_q == '0) begin
      n_eff = CfgW'(1);
    end else if (32'(cells_q) > MaxCells) begin
      n_eff = CfgW'(MaxCells);
    end
  end

  // byte as signed char, then both hash updates
  assign byte_ext = {{(HashW-8){s_axis_tdata[7]}}, s_axis_tdata[7:0]};
  assign h1_upd   = (h1_q << 5) + h1_q + byte_ext;
  assign h2_upd   = (h2_q << 6) + (h2_q << 16) - h2_q + byte_ext;

  // one restoring step: bring in next dividend bit, subtract if it fits
  function automatic logic [CfgW-1:0] rem_step(logic [CfgW-1:0] rem, logic nbit,
                                               logic [CfgW-1:0] n);
    logic [CfgW:0] t;
    t = {rem, nbit};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[CfgW-1:0];
  endfunction

  assign addr_a = AddrW'(r1_q);
  assign addr_b = AddrW'(r2_q);

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataOutW-1){1'b0}}, out_data_q[1]};
  assign m_axis_tuser  = out_data_q[0];

  // store port steering; read address held on the second bit while stalled
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b1;
    mem_waddr = addr_a;
    mem_raddr = (state_q == StAddrB || state_q == StRes) ? addr_b : addr_a;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_waddr = clr_q[AddrW-1:0];
      end
      StAddrA: begin
        mem_we = (func_q == FuncInsert);
      end
      StAddrB: begin
        mem_we    = (func_q == FuncInsert);
        mem_waddr = addr_b;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    q1_d        = q1_q;
    q2_d        = q2_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    step_d      = step_q;
    clr_d       = clr_q;
    func_d      = func_q;
    bit_a_d     = bit_a_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(MaxCells - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser[1]) begin
            h1_d = h1_upd;
            h2_d = h2_upd;
          end
          if (s_axis_tlast) begin
            q1_d    = s_axis_tuser[1] ? h1_upd : h1_q;
            q2_d    = s_axis_tuser[1] ? h2_upd : h2_q;
            r1_d    = '0;
            r2_d    = '0;
            step_d  = '0;
            func_d  = s_axis_tuser[0];
            h1_d    = Djb2Start;
            h2_d    = SdbmStart;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        r1_d   = rem_step(r1_q, q1_q[HashW-1], n_eff);
        r2_d   = rem_step(r2_q, q2_q[HashW-1], n_eff);
        q1_d   = q1_q << 1;
        q2_d   = q2_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(HashW - 1)) begin
          state_d = StAddrA;
        end
      end
      StAddrA: begin
        state_d = StAddrB;
      end
      StAddrB: begin
        bit_a_d = mem_rdata;           // first bit, read last cycle
        state_d = StRes;
      end
      StRes: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {(func_q == FuncQuery) && bit_a_q && mem_rdata, func_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cells_q     <= CellCountRst;
      h1_q        <= Djb2Start;
      h2_q        <= SdbmStart;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h1_q        <= h1_d;
      h2_q        <= h2_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cells_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    q1_q       <= q1_d;
    q2_q       <= q2_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    func_q     <= func_d;
    bit_a_q    <= bit_a_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== design/bfsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfsm_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
